>>> hdl/ufv_pkg.sv
// Shared types, constants and verdict function for the UTF-8 filename validator.
`timescale 1ns / 1ps
`default_nettype none

package ufv_pkg;

	// Longest name or component accepted, in bytes.
	localparam int MAX_NAME_BYTES = 255;
	// Length counter saturates at MAX_NAME_BYTES + 1.
	localparam int LEN_W = $clog2(MAX_NAME_BYTES + 2);

	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_DEL    = 8'h7F;
	localparam logic [7:0] CH_CONT_L = 8'h80;
	localparam logic [7:0] CH_C1_HI  = 8'h9F;

	// Allowed range for the next continuation byte.
	typedef enum logic [2:0] {
		CC_80_BF = 3'd0,
		CC_A0_BF = 3'd1,
		CC_80_9F = 3'd2,
		CC_90_BF = 3'd3,
		CC_80_8F = 3'd4
	} cont_class_t;

	// Decoder state of the current component.
	typedef struct packed {
		logic [1:0]       pend;
		cont_class_t      cls;
		logic [LEN_W-1:0] len;
		logic             bad;
		logic             not_dots;
	} comp_state_t;

	// Result of looking at one byte outside a path separator.
	typedef struct packed {
		logic        bad;
		logic [1:0]  pend;
		cont_class_t cls;
	} byte_eval_t;

	function automatic logic comp_verdict(input comp_state_t st);
		logic ok;
		ok = 1'b1;
		if (st.bad || st.pend != 2'd0)
			ok = 1'b0;
		if (st.len == '0 || st.len > LEN_W'(MAX_NAME_BYTES))
			ok = 1'b0;
		if (!st.not_dots && st.len <= LEN_W'(2))
			ok = 1'b0;
		return ok;
	endfunction

endpackage

`default_nettype wire

>>> hdl/utf8_filename_validator.sv
// Top level of the streaming strict UTF-8 filename validator.
`timescale 1ns / 1ps
`default_nettype none

// Checks a file name, or in path mode the last non-empty component of a path,
// streamed in one byte per request. A name is valid when it has 1 to
// MAX_NAME_BYTES bytes, is neither "." nor "..", is strict UTF-8 (no overlong
// forms, no surrogates, nothing above U+10FFFF, no truncated sequence) and holds
// no '/', no C0 control, no DEL and no C1 control. The request with tlast high
// closes the name and produces exactly one verdict on the master side; a request
// with tlast high and tuser low closes it without adding a byte. Requests with
// both low are dropped. Throughput is one request per clock: an input register
// feeds byte classification and state update, and the verdict of the closing
// request is written into the output register.
// The only stall is a closing request held in the input register while an
// earlier verdict still waits in the output register.
// path_mode is written over the cfg channel and must only change while no
// request is in flight; a change inside a name applies from the next byte on.

module utf8_filename_validator (
	input  wire logic       clk,
	input  wire logic       arst_n,
	// configuration
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic       cfg_data,       // path_mode
	// byte stream in
	input  wire logic       s_axis_tvalid,
	output logic            s_axis_tready,
	input  wire logic [7:0] s_axis_tdata,   // [7:0] data_byte
	input  wire logic       s_axis_tuser,   // [0] byte_present
	input  wire logic       s_axis_tlast,   // end_of_name
	// verdict out
	output logic            m_axis_tvalid,
	input  wire logic       m_axis_tready,
	output logic [7:0]      m_axis_tdata    // [0] name_ok, [7:1] zero
);

	logic       path_mode_q;
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       present_s1;
	logic       last_s1;
	logic       fire;
	logic       name_ok;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			path_mode_q <= 1'b0;
		else if (cfg_valid)
			path_mode_q <= cfg_data;
	end

	// Stage 1 moves on unless it closes a name while the verdict slot is full and not being read.
	assign fire          = valid_s1 && (!last_s1 || !m_axis_tvalid || m_axis_tready);
	assign s_axis_tready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_axis_tready)
			valid_s1 <= s_axis_tvalid && (s_axis_tuser || s_axis_tlast);
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready) begin
			byte_s1    <= s_axis_tdata;
			present_s1 <= s_axis_tuser;
			last_s1    <= s_axis_tlast;
		end
	end

	ufv_name_tracker u_tracker (
		.clk          (clk),
		.arst_n       (arst_n),
		.path_mode    (path_mode_q),
		.fire         (fire),
		.data_byte    (byte_s1),
		.byte_present (present_s1),
		.end_of_name  (last_s1),
		.res_ready    (m_axis_tready),
		.res_valid    (m_axis_tvalid),
		.name_ok      (name_ok)
	);

	assign m_axis_tdata = {7'd0, name_ok};

endmodule

`default_nettype wire

>>> hdl/ufv_byte_class.sv
// Strict UTF-8 and control-character classification of one byte.
`timescale 1ns / 1ps
`default_nettype none

module ufv_byte_class (
	input  wire logic [7:0]          data_byte,
	input  wire logic [1:0]          pend,
	input  wire ufv_pkg::cont_class_t cls,
	output ufv_pkg::byte_eval_t      eval
);

	logic fits;

	always_comb begin
		unique case (cls)
			ufv_pkg::CC_A0_BF: fits = data_byte >= 8'hA0 && data_byte <= 8'hBF;
			ufv_pkg::CC_80_9F: fits = data_byte >= 8'h80 && data_byte <= 8'h9F;
			ufv_pkg::CC_90_BF: fits = data_byte >= 8'h90 && data_byte <= 8'hBF;
			ufv_pkg::CC_80_8F: fits = data_byte >= 8'h80 && data_byte <= 8'h8F;
			default:           fits = data_byte >= 8'h80 && data_byte <= 8'hBF;
		endcase
	end

	always_comb begin
		eval.bad  = 1'b0;
		eval.pend = 2'd0;
		eval.cls  = ufv_pkg::CC_80_BF;
		if (pend != 2'd0) begin
			// inside a sequence
			if (fits)
				eval.pend = pend - 2'd1;
			else
				eval.bad = 1'b1;
		end else if (data_byte < ufv_pkg::CH_CONT_L) begin
			eval.bad = data_byte < ufv_pkg::CH_SPACE || data_byte == ufv_pkg::CH_DEL ||
				data_byte == ufv_pkg::CH_SLASH;
		end else if (data_byte < 8'hC2) begin
			eval.bad = 1'b1; // stray continuation or overlong two-byte lead
		end else if (data_byte < 8'hE0) begin
			eval.pend = 2'd1;
			// C2 followed by 80-9F would be a C1 control
			if (data_byte == 8'hC2)
				eval.cls = ufv_pkg::CC_A0_BF;
		end else if (data_byte < 8'hF0) begin
			eval.pend = 2'd2;
			if (data_byte == 8'hE0)
				eval.cls = ufv_pkg::CC_A0_BF;
			else if (data_byte == 8'hED)
				eval.cls = ufv_pkg::CC_80_9F;
		end else if (data_byte < 8'hF5) begin
			eval.pend = 2'd3;
			if (data_byte == 8'hF0)
				eval.cls = ufv_pkg::CC_90_BF;
			else if (data_byte == 8'hF4)
				eval.cls = ufv_pkg::CC_80_8F;
		end else begin
			eval.bad = 1'b1;
		end
	end

endmodule

`default_nettype wire

>>> hdl/ufv_name_tracker.sv
// Per-component state, saved verdict and registered result.
`timescale 1ns / 1ps
`default_nettype none

module ufv_name_tracker (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       path_mode,
	input  wire logic       fire,
	input  wire logic [7:0] data_byte,
	input  wire logic       byte_present,
	input  wire logic       end_of_name,
	input  wire logic       res_ready,
	output logic            res_valid,
	output logic            name_ok
);

	ufv_pkg::comp_state_t st_q, st_byte, st_clear;
	ufv_pkg::byte_eval_t  eval;
	logic                 saved_q, have_saved_q;
	logic                 saved_byte, have_byte;
	logic                 sep;
	logic                 ok;
	logic                 res_valid_q, name_ok_q;

	ufv_byte_class u_class (
		.data_byte (data_byte),
		.pend      (st_q.pend),
		.cls       (st_q.cls),
		.eval      (eval)
	);

	assign st_clear = '{pend: 2'd0, cls: ufv_pkg::CC_80_BF, len: '0, bad: 1'b0,
		not_dots: 1'b0};
	assign sep = path_mode && data_byte == ufv_pkg::CH_SLASH;

	// state after the byte of this request
	always_comb begin
		st_byte    = st_q;
		saved_byte = saved_q;
		have_byte  = have_saved_q;
		if (byte_present) begin
			if (sep) begin
				if (st_q.len != '0) begin
					saved_byte = ufv_pkg::comp_verdict(st_q);
					have_byte  = 1'b1;
				end
				st_byte = st_clear;
			end else begin
				if (st_q.len <= ufv_pkg::LEN_W'(ufv_pkg::MAX_NAME_BYTES))
					st_byte.len = st_q.len + ufv_pkg::LEN_W'(1);
				if (data_byte != ufv_pkg::CH_DOT)
					st_byte.not_dots = 1'b1;
				st_byte.pend = eval.pend;
				st_byte.cls  = eval.cls;
				if (eval.bad)
					st_byte.bad = 1'b1;
			end
		end
	end

	always_comb begin
		if (st_byte.len != '0)
			ok = ufv_pkg::comp_verdict(st_byte);
		else
			ok = path_mode && have_byte && saved_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= st_clear;
			saved_q      <= 1'b0;
			have_saved_q <= 1'b0;
			res_valid_q  <= 1'b0;
		end else begin
			if (fire) begin
				if (end_of_name) begin
					st_q         <= st_clear;
					saved_q      <= 1'b0;
					have_saved_q <= 1'b0;
				end else begin
					st_q         <= st_byte;
					saved_q      <= saved_byte;
					have_saved_q <= have_byte;
				end
			end
			if (fire && end_of_name)
				res_valid_q <= 1'b1;
			else if (res_ready)
				res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && end_of_name)
			name_ok_q <= ok;
	end

	assign res_valid = res_valid_q;
	assign name_ok   = name_ok_q;

endmodule

`default_nettype wire

>>> hdl/ufv_checker.sv
// Port-level checks for the filename validator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module ufv_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       s_axis_tready,
	input wire logic       m_axis_tvalid,
	input wire logic       m_axis_tready,
	input wire logic [7:0] m_axis_tdata
);

	// verdict held until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("verdict dropped or changed while stalled");

	// only bit 0 carries information
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[7:1] == 7'd0)
		else $error("verdict padding bits not zero");

	// a free output side never backs up the input
	a_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tready |-> s_axis_tready)
		else $error("input stalled while output is ready");

	// with no verdict pending, the input is always open
	a_open_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with empty output register");

endmodule

bind utf8_filename_validator ufv_checker u_ufv_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
